// File: rtl/pdsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdsr_pkg
// Shared types and constants of the polar depth span rasterizer.
// ----------------------------------------------------------------------------
package pdsr_pkg;

  localparam int BUCKETS_DEF = 256;

  localparam int DATA_W  = 24;
  localparam int ANGLE_W = 24;
  localparam int SCALE_W = 24;
  localparam int INDEX_W = 16;
  localparam int OP_W    = 2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'h010000;

  // angle * scale is Q.24, bucket is the integer part after adding one half
  localparam int FRAC_BITS = 24;
  localparam int PROD_W    = ANGLE_W + SCALE_W + 1;
  localparam int BKT_W     = PROD_W - FRAC_BITS;

  // radius difference and interpolation offset
  localparam int DIFF_W = DATA_W + 1;
  localparam int QUO_W  = DATA_W + 1;
  localparam int OFS_W  = DATA_W + 2;
  localparam int CNT_W  = $clog2(QUO_W);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_READ_WAIT,
    ST_MUL_BEGIN,
    ST_MUL_END,
    ST_MAP_END,
    ST_CLIP,
    ST_DIV,
    ST_STEP,
    ST_WALK,
    ST_WALK_LAST,
    ST_DONE
  } state_e;

endpackage

// File: rtl/polar_depth_span_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_depth_span_rasterizer
// One-dimensional depth buffer indexed by angle: clear, span draw with
// linear radius interpolation and min merge, and bucket read.
//
//   channel  direction  handshake                    payload
//   config   in         cfg_we_i                     cfg_wdata_i (angle scale)
//   request  in         in_valid_i / in_stall_o      op_i .. read_index_i
//   result   out        out_valid_o / out_stall_i    read_value_o
//
// clear: one bucket written per cycle
// read: goes through the registered memory read
// draw: shared multiplier, divider for the slope, then a read-modify-write
//   walk of one bucket per cycle
// after reset a clearing pass zeroes the memory, requests stall
// a stalled result holds the output register; the next request is taken meanwhile
// ----------------------------------------------------------------------------
module polar_depth_span_rasterizer #(
  parameter int BUCKETS = pdsr_pkg::BUCKETS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic        [pdsr_pkg::SCALE_W-1:0]    cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic        [pdsr_pkg::OP_W-1:0]       op_i,
  input  logic signed [pdsr_pkg::ANGLE_W-1:0]    angle_begin_i,
  input  logic signed [pdsr_pkg::DATA_W-1:0]     radius_begin_i,
  input  logic signed [pdsr_pkg::ANGLE_W-1:0]    angle_end_i,
  input  logic signed [pdsr_pkg::DATA_W-1:0]     radius_end_i,
  input  logic signed [pdsr_pkg::DATA_W-1:0]     fill_value_i,
  input  logic signed [pdsr_pkg::INDEX_W-1:0]    read_index_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [pdsr_pkg::DATA_W-1:0]     read_value_o
);

  localparam int IDX_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int DATA_W = pdsr_pkg::DATA_W;
  localparam int PROD_W = pdsr_pkg::PROD_W;
  localparam int BKT_W  = pdsr_pkg::BKT_W;
  localparam int DIFF_W = pdsr_pkg::DIFF_W;
  localparam int QUO_W  = pdsr_pkg::QUO_W;
  localparam int OFS_W  = pdsr_pkg::OFS_W;
  localparam int CNT_W  = pdsr_pkg::CNT_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKETS - 1);
  localparam logic signed [BKT_W-1:0] BKT_SIZE = BKT_W'(BUCKETS);
  localparam logic signed [BKT_W-1:0] BKT_LAST = BKT_W'(BUCKETS - 1);
  localparam logic signed [pdsr_pkg::INDEX_W-1:0] RD_SIZE =
    pdsr_pkg::INDEX_W'(BUCKETS);
  localparam logic signed [PROD_W-1:0] ROUND_BIAS =
    PROD_W'(1) << (pdsr_pkg::FRAC_BITS - 1);

  pdsr_pkg::state_e state_q, state_d;

  logic                            init_q, init_d;
  logic        [IDX_W-1:0]         x_q, x_d;
  logic        [IDX_W-1:0]         xend_q, xend_d;
  logic        [IDX_W-1:0]         den_q, den_d;
  logic signed [DATA_W-1:0]        fill_q, fill_d;
  logic signed [pdsr_pkg::ANGLE_W-1:0] ab_q, ab_d, ae_q, ae_d;
  logic signed [DATA_W-1:0]        rb_q, rb_d, re_q, re_d;
  logic        [IDX_W-1:0]         ridx_q, ridx_d;
  logic signed [DATA_W-1:0]        res_q, res_d;
  logic signed [PROD_W-1:0]        prod_q, prod_d;
  logic signed [BKT_W-1:0]         xb_q, xb_d, xe_q, xe_d;
  logic        [QUO_W-1:0]         quo_q, quo_d;
  logic        [IDX_W-1:0]         rem_q, rem_d;
  logic        [CNT_W-1:0]         cnt_q, cnt_d;
  logic                            neg_q, neg_d;
  logic signed [OFS_W-1:0]         stq_q, stq_d;
  logic        [IDX_W:0]           str_q, str_d;
  logic signed [OFS_W-1:0]         q_q, q_d;
  logic        [IDX_W:0]           r_q, r_d;
  logic signed [DATA_W-1:0]        val_q, val_d;
  logic        [IDX_W-1:0]         waddr_q, waddr_d;
  logic                            pend_q, pend_d;
  logic                            out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0]        out_data_q, out_data_d;
  logic        [pdsr_pkg::SCALE_W-1:0] scale_q;

  logic                            ram_we;
  logic        [IDX_W-1:0]         ram_waddr;
  logic signed [DATA_W-1:0]        ram_wdata;
  logic        [IDX_W-1:0]         ram_raddr;
  logic signed [DATA_W-1:0]        ram_rdata;

  // shared datapath terms
  logic signed [pdsr_pkg::ANGLE_W-1:0] mul_a;
  logic signed [PROD_W-1:0]        prod_w;
  logic signed [PROD_W-1:0]        bias_sum;
  logic signed [BKT_W-1:0]         bucket;
  logic                            drop;
  logic        [IDX_W-1:0]         cxb, cxe;
  logic signed [DIFF_W-1:0]        diff;
  logic        [IDX_W:0]           div_shift;
  logic                            div_ge;
  logic        [IDX_W+1:0]         two_den;
  logic        [IDX_W+1:0]         r_sum;
  logic                            r_wrap;
  logic signed [OFS_W-1:0]         v_full;
  logic signed [DATA_W-1:0]        v_clamp;
  logic signed [DATA_W-1:0]        v_min;
  logic                            rd_in_range;

  assign mul_a    = (state_q == pdsr_pkg::ST_MUL_BEGIN) ? ab_q : ae_q;
  assign prod_w   = mul_a * $signed({1'b0, scale_q});
  assign bias_sum = prod_q + ROUND_BIAS;
  assign bucket   = bias_sum[PROD_W-1:pdsr_pkg::FRAC_BITS];

  assign drop = (xe_q < 0) || (xb_q >= BKT_SIZE);
  assign cxb  = (xb_q < 0) ? '0 : xb_q[IDX_W-1:0];
  assign cxe  = (xe_q > BKT_LAST) ? LAST_IDX : xe_q[IDX_W-1:0];
  assign diff = DIFF_W'(re_q) - DIFF_W'(rb_q);

  assign div_shift = {rem_q, quo_q[QUO_W-1]};
  assign div_ge    = div_shift >= {1'b0, den_q};

  assign two_den = {1'b0, den_q, 1'b0};
  assign r_sum   = {1'b0, r_q} + {1'b0, str_q};
  assign r_wrap  = r_sum >= two_den;

  assign v_full  = OFS_W'(rb_q) + q_q;
  assign v_clamp = v_full[OFS_W-1] ? '0 : v_full[DATA_W-1:0];
  assign v_min   = (val_q < ram_rdata) ? val_q : ram_rdata;

  assign rd_in_range = (read_index_i >= 0) && (read_index_i < RD_SIZE);

  always_comb begin
    logic [QUO_W-1:0] abs_q;
    logic [IDX_W-1:0] rem_fix;

    abs_q   = '0;
    rem_fix = '0;

    state_d     = state_q;
    init_d      = init_q;
    x_d         = x_q;
    xend_d      = xend_q;
    den_d       = den_q;
    fill_d      = fill_q;
    ab_d        = ab_q;
    ae_d        = ae_q;
    rb_d        = rb_q;
    re_d        = re_q;
    ridx_d      = ridx_q;
    res_d       = res_q;
    prod_d      = prod_q;
    xb_d        = xb_q;
    xe_d        = xe_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    stq_d       = stq_q;
    str_d       = str_q;
    q_d         = q_q;
    r_d         = r_q;
    val_d       = val_q;
    waddr_d     = waddr_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    ram_we    = 1'b0;
    ram_waddr = x_q;
    ram_wdata = fill_q;
    ram_raddr = x_q;

    in_stall_o = (state_q != pdsr_pkg::ST_IDLE);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      pdsr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          res_d = '0;
          if (angle_begin_i > angle_end_i) begin
            ab_d = angle_end_i;
            ae_d = angle_begin_i;
            rb_d = radius_end_i;
            re_d = radius_begin_i;
          end else begin
            ab_d = angle_begin_i;
            ae_d = angle_end_i;
            rb_d = radius_begin_i;
            re_d = radius_end_i;
          end
          fill_d = fill_value_i;
          x_d    = '0;
          ridx_d = rd_in_range ? read_index_i[IDX_W-1:0] : '0;
          case (pdsr_pkg::op_e'(op_i))
            pdsr_pkg::OP_CLEAR: state_d = pdsr_pkg::ST_CLEAR;
            pdsr_pkg::OP_DRAW:  state_d = pdsr_pkg::ST_MUL_BEGIN;
            pdsr_pkg::OP_READ:  state_d = pdsr_pkg::ST_READ;
            default:            state_d = pdsr_pkg::ST_DONE;
          endcase
        end
      end
      pdsr_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        x_d    = x_q + 1'b1;
        if (x_q == LAST_IDX) begin
          init_d  = 1'b0;
          state_d = init_q ? pdsr_pkg::ST_IDLE : pdsr_pkg::ST_DONE;
        end
      end
      pdsr_pkg::ST_READ: begin
        ram_raddr = ridx_q;
        state_d   = pdsr_pkg::ST_READ_WAIT;
      end
      pdsr_pkg::ST_READ_WAIT: begin
        res_d   = ram_rdata;
        state_d = pdsr_pkg::ST_DONE;
      end
      pdsr_pkg::ST_MUL_BEGIN: begin
        prod_d  = prod_w;
        state_d = pdsr_pkg::ST_MUL_END;
      end
      pdsr_pkg::ST_MUL_END: begin
        xb_d    = bucket;
        prod_d  = prod_w;
        state_d = pdsr_pkg::ST_MAP_END;
      end
      pdsr_pkg::ST_MAP_END: begin
        xe_d    = bucket;
        state_d = pdsr_pkg::ST_CLIP;
      end
      pdsr_pkg::ST_CLIP: begin
        if (drop) begin
          state_d = pdsr_pkg::ST_DONE;
        end else if (cxb >= cxe) begin
          // one-bucket span overwrites unclamped
          ram_we    = 1'b1;
          ram_waddr = cxb;
          ram_wdata = rb_q;
          state_d   = pdsr_pkg::ST_DONE;
        end else begin
          abs_q   = diff[DIFF_W-1] ? QUO_W'(-diff) : QUO_W'(diff);
          x_d     = cxb;
          xend_d  = cxe;
          den_d   = cxe - cxb;
          neg_d   = diff[DIFF_W-1];
          quo_d   = abs_q;
          rem_d   = '0;
          cnt_d   = CNT_W'(QUO_W - 1);
          state_d = pdsr_pkg::ST_DIV;
        end
      end
      pdsr_pkg::ST_DIV: begin
        rem_d = div_ge ? IDX_W'(div_shift - {1'b0, den_q}) : div_shift[IDX_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], div_ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = pdsr_pkg::ST_STEP;
        end
      end
      pdsr_pkg::ST_STEP: begin
        // floor division of the radius difference by the span
        if (neg_q && (rem_q != '0)) begin
          stq_d   = -$signed(OFS_W'(quo_q)) - OFS_W'(1);
          rem_fix = den_q - rem_q;
        end else if (neg_q) begin
          stq_d   = -$signed(OFS_W'(quo_q));
          rem_fix = '0;
        end else begin
          stq_d   = $signed(OFS_W'(quo_q));
          rem_fix = rem_q;
        end
        str_d   = {rem_fix, 1'b0};
        q_d     = '0;
        r_d     = {1'b0, den_q};
        pend_d  = 1'b0;
        state_d = pdsr_pkg::ST_WALK;
      end
      pdsr_pkg::ST_WALK: begin
        ram_raddr = x_q;
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = waddr_q;
          ram_wdata = v_min;
        end
        val_d   = v_clamp;
        waddr_d = x_q;
        pend_d  = 1'b1;
        if (r_wrap) begin
          r_d = (IDX_W+1)'(r_sum - two_den);
          q_d = q_q + stq_q + OFS_W'(1);
        end else begin
          r_d = r_sum[IDX_W:0];
          q_d = q_q + stq_q;
        end
        if (x_q == xend_q) begin
          state_d = pdsr_pkg::ST_WALK_LAST;
        end else begin
          x_d = x_q + 1'b1;
        end
      end
      pdsr_pkg::ST_WALK_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = waddr_q;
        ram_wdata = v_min;
        pend_d    = 1'b0;
        state_d   = pdsr_pkg::ST_DONE;
      end
      pdsr_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = pdsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pdsr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pdsr_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q      <= 1'b1;
      x_q         <= '0;
      fill_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      scale_q     <= pdsr_pkg::SCALE_RESET;
    end else begin
      init_q      <= init_d;
      x_q         <= x_d;
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    xend_q     <= xend_d;
    den_q      <= den_d;
    ab_q       <= ab_d;
    ae_q       <= ae_d;
    rb_q       <= rb_d;
    re_q       <= re_d;
    ridx_q     <= ridx_d;
    res_q      <= res_d;
    prod_q     <= prod_d;
    xb_q       <= xb_d;
    xe_q       <= xe_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    neg_q      <= neg_d;
    stq_q      <= stq_d;
    str_q      <= str_d;
    q_q        <= q_d;
    r_q        <= r_d;
    val_q      <= val_d;
    waddr_q    <= waddr_d;
    out_data_q <= out_data_d;
  end

  pdsr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BUCKETS)
  ) u_buckets (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_data_q;

`ifndef SYNTHESIS
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pdsr_pkg::ST_WALK) |-> (x_q <= xend_q))
    else $error("walk index past span end");

  a_dda_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pdsr_pkg::ST_WALK) |-> ({1'b0, r_q} < two_den))
    else $error("interpolation remainder out of range");

  a_read_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pdsr_pkg::ST_READ || state_q == pdsr_pkg::ST_READ_WAIT) |-> !ram_we)
    else $error("memory write during read transaction");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != pdsr_pkg::ST_IDLE))
    else $error("accepted transaction did not start");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == pdsr_pkg::ST_DONE))
    else $error("result raised outside completion");
`endif

endmodule

// File: rtl/pdsr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdsr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pdsr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
